[hdl/psm_pkg.sv]
// Package for the parallel selection-sampling marker.
// Types, widths and register indexes shared by all hdl files. No dependencies.
package psm_pkg;

   localparam int COIN_W    = 32;
   localparam int ITEM_W    = 32;
   localparam int SUB_OUT_W = 6;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int SUBCNT_W  = 7;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_ITEMS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUBSET_COUNT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP
   } psm_state_type;

   // operands handed to the decision unit
   typedef struct packed {
      logic              start;
      logic [COIN_W-1:0] coin;
      logic [ITEM_W-1:0] remain;
      logic [ITEM_W-1:0] left;
   } psm_dec_req_type;

   // decision unit result
   typedef struct packed {
      logic              marked;
      logic [ITEM_W-1:0] left_now;
      logic [ITEM_W-1:0] left_next;
   } psm_dec_res_type;

endpackage

[hdl/psm_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on psm_pkg for field widths.
interface psm_req_if;
   import psm_pkg::*;
   logic              valid;
   logic              ready;
   logic [COIN_W-1:0] coin_data;

   modport source (output valid, output coin_data, input ready);
   modport sink   (input valid, input coin_data, output ready);
endinterface

interface psm_rsp_if;
   import psm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ITEM_W-1:0]    item_index;
   logic [SUB_OUT_W-1:0] subset_index;
   logic                 marked;
   logic                 last_of_row;

   modport source (output valid, output item_index, output subset_index,
                   output marked, output last_of_row, input ready);
   modport sink   (input valid, input item_index, input subset_index,
                   input marked, input last_of_row, output ready);
endinterface

[hdl/psm_count_mem.sv]
// Per-subset remaining-count memory: one write port, one registered read port.
// Depends on psm_pkg for the count width.
module psm_count_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [psm_pkg::ITEM_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [psm_pkg::ITEM_W-1:0] rd_data
);
   import psm_pkg::*;

   logic [ITEM_W-1:0] mem [DEPTH];
   logic [ITEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/psm_decide.sv]
// Keep/skip decision: coin < (left << 32) / remain, evaluated without a divider
// as (coin + 1) * remain <= left << 32. Depends on psm_pkg.
module psm_decide (
   input  logic                        clock,
   input  psm_pkg::psm_dec_req_type    dec_req,
   output psm_pkg::psm_dec_res_type    dec_res
);
   import psm_pkg::*;

   logic [2*ITEM_W-1:0] product_ff;
   logic [2*ITEM_W-1:0] product_in;
   logic [ITEM_W-1:0]   remain_ff;
   logic [ITEM_W-1:0]   left_ff;
   logic [2*ITEM_W:0]   lhs;
   logic [2*ITEM_W:0]   rhs;

   assign product_in = {{ITEM_W{1'b0}}, dec_req.coin} * {{ITEM_W{1'b0}}, dec_req.remain};

   always_ff @(posedge clock) begin
      if (dec_req.start) begin
         product_ff <= product_in;
         remain_ff  <= dec_req.remain;
         left_ff    <= dec_req.left;
      end
   end

   // floor(x) > coin  <=>  x >= coin + 1
   assign lhs = {1'b0, product_ff} + {{(ITEM_W+1){1'b0}}, remain_ff};
   assign rhs = {1'b0, left_ff, {ITEM_W{1'b0}}};

   always_comb begin
      dec_res.marked    = (lhs <= rhs);
      dec_res.left_now  = left_ff;
      dec_res.left_next = dec_res.marked ? (left_ff - ITEM_W'(1)) : left_ff;
   end

endmodule

[hdl/parallel_selection_sampling_marker_top.sv]
// Top level of the parallel selection-sampling marker.
// Depends on psm_pkg, psm_if, psm_count_mem and psm_decide.
//
// Usage:
//  - req_ch carries one 32-bit random coin per transaction. Coins are used
//    item-major, subset-minor: for each item, subsets 0 .. k-1 in turn.
//  - rsp_ch returns one transaction per coin: item index, subset index, the
//    mark bit and a last-of-row flag on the final subset of each item.
//  - csr port: write enable, index (0 total_items, 1 sample_size,
//    2 subset_count) and data. Any write to a listed register re-arms the
//    run (item 0, subset 0, all counts at min(m, n)). Write only when idle.
//  - Timing: a coin is taken in ST_IDLE, which also issues the count memory
//    read; ST_MUL forms the coin * remaining product on one 32x32 multiplier;
//    ST_CMP compares and writes the count back. A new coin is taken only
//    after ST_CMP retires the last one, which also loads the response
//    register. The memory read latency and the registered product set these
//    three steps.
//  - The response register lets a new coin be accepted while a result waits;
//    if it is still full when the next result is ready, ST_CMP holds.
//  - Reset clears the control state and configuration (n = 1, m = 0, k = 1).
//    No clearing pass: during item 0 the counts are taken from the clamped
//    sample size, and every subset's entry is written before it is read.
module parallel_selection_sampling_marker_top #(
   parameter int MAX_SUBSETS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   psm_req_if.sink                        req_ch,
   psm_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [psm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psm_pkg::CSR_W-1:0]      csr_wdata
);
   import psm_pkg::*;

   localparam int SUB_W = (MAX_SUBSETS > 1) ? $clog2(MAX_SUBSETS) : 1;
   localparam int KW    = SUB_W + 1;
   localparam logic [31:0] MAX_SUB_W32 = 32'(MAX_SUBSETS);

   // configuration
   logic [ITEM_W-1:0]   total_items_ff;
   logic [ITEM_W-1:0]   sample_size_ff;
   logic [SUBCNT_W-1:0] subset_count_ff;

   // position and working registers
   logic [ITEM_W-1:0]   item_ff, item_in;
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [COIN_W-1:0]   coin_ff;
   logic [ITEM_W-1:0]   remain_ff;

   psm_state_type       state_ff, state_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]    rsp_item_ff;
   logic [SUB_OUT_W-1:0] rsp_sub_ff;
   logic                 rsp_mark_ff;
   logic                 rsp_last_ff;

   // derived configuration
   logic [ITEM_W-1:0]   n_eff;
   logic [ITEM_W-1:0]   m_eff;
   logic [31:0]         k_wide;
   logic [KW-1:0]       k_eff;

   logic                accept;
   logic                out_free;
   logic                cmp_done;
   logic                cfg_rearm;
   logic                last_sub;
   logic                last_item;
   logic [ITEM_W-1:0]   rd_count;

   psm_dec_req_type     dec_req;
   psm_dec_res_type     dec_res;

   // effective n, m, k with the clamps applied
   always_comb begin
      n_eff = (total_items_ff == '0) ? ITEM_W'(1) : total_items_ff;
      m_eff = (sample_size_ff > n_eff) ? n_eff : sample_size_ff;
      k_wide = {{(32-SUBCNT_W){1'b0}}, subset_count_ff};
      if (k_wide == 32'd0) begin
         k_wide = 32'd1;
      end else if (k_wide > MAX_SUB_W32) begin
         k_wide = MAX_SUB_W32;
      end
      k_eff = k_wide[KW-1:0];
   end

   assign cfg_rearm = csr_wr_en && ((csr_index == REG_TOTAL_ITEMS) ||
                                    (csr_index == REG_SAMPLE_SIZE) ||
                                    (csr_index == REG_SUBSET_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         total_items_ff  <= ITEM_W'(1);
         sample_size_ff  <= '0;
         subset_count_ff <= SUBCNT_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TOTAL_ITEMS:  total_items_ff  <= csr_wdata;
            REG_SAMPLE_SIZE:  sample_size_ff  <= csr_wdata;
            REG_SUBSET_COUNT: subset_count_ff <= csr_wdata[SUBCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- control FSM ----------------
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_CMP;
         ST_CMP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      cmp_done = (state_ff == ST_CMP) && out_free;
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture coin and items remaining at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         coin_ff   <= req_ch.coin_data;
         remain_ff <= n_eff - item_ff;
      end
   end

   // count memory: read at acceptance, write back when the decision retires
   psm_count_mem #(
      .DEPTH (MAX_SUBSETS),
      .AW    (SUB_W)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (cmp_done),
      .wr_addr (sub_ff),
      .wr_data (dec_res.left_next),
      .rd_en   (accept),
      .rd_addr (sub_ff),
      .rd_data (rd_count)
   );

   // item 0 of a run starts from the rearm value; memory is stale there
   always_comb begin
      dec_req.start  = (state_ff == ST_MUL);
      dec_req.coin   = coin_ff;
      dec_req.remain = remain_ff;
      dec_req.left   = (item_ff == '0) ? m_eff : rd_count;
   end

   psm_decide u_decide (
      .clock   (clock),
      .dec_req (dec_req),
      .dec_res (dec_res)
   );

   // ---------------- position advance ----------------
   assign last_sub  = ((KW'(sub_ff) + KW'(1)) == k_eff);
   assign last_item = (({1'b0, item_ff} + 33'd1) >= {1'b0, n_eff});

   always_comb begin
      item_in = item_ff;
      sub_in  = sub_ff;
      if (cfg_rearm) begin
         item_in = '0;
         sub_in  = '0;
      end else if (cmp_done) begin
         if (last_sub) begin
            sub_in  = '0;
            item_in = last_item ? '0 : (item_ff + ITEM_W'(1));
         end else begin
            sub_in = sub_ff + SUB_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
         sub_ff  <= '0;
      end else begin
         item_ff <= item_in;
         sub_ff  <= sub_in;
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      if (cmp_done) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_done) begin
         rsp_item_ff <= item_ff;
         rsp_sub_ff  <= SUB_OUT_W'(sub_ff);
         rsp_mark_ff <= dec_res.marked;
         rsp_last_ff <= last_sub;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.item_index   = rsp_item_ff;
   assign rsp_ch.subset_index = rsp_sub_ff;
   assign rsp_ch.marked       = rsp_mark_ff;
   assign rsp_ch.last_of_row  = rsp_last_ff;

   // ---------------- assertions ----------------
   a_item_in_range: assert property (@(posedge clock) disable iff (reset)
      item_ff < n_eff)
      else $error("item position beyond population");

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      KW'(sub_ff) < k_eff)
      else $error("subset position beyond subset count");

   a_load_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CMP))
      else $error("response loaded outside compare step");

   a_mark_needs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) && dec_res.marked |-> dec_res.left_now != '0)
      else $error("mark with exhausted count");

endmodule
